/* hw/rtl/gbpf_pkg.sv */
// gbpf_pkg: types and constants for the page framebuffer glyph writer
// used by glyph_blit_page_framebuffer; no dependencies
package gbpf_pkg;

    localparam int DISPLAY_WIDTH_DEF  = 128;
    localparam int DISPLAY_HEIGHT_DEF = 64;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BITMAP = 2'd1,
        KIND_FILL   = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_BITS,
        ST_DRAIN,
        ST_READ
    } state_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         origin_x;
        logic [7:0]         origin_y;
        logic signed [7:0]  x_offset;
        logic signed [7:0]  y_offset;
        logic [7:0]         glyph_width;
        logic [7:0]         glyph_height;
        logic [7:0]         bitmap_byte;
        logic               fill_ones;
        logic [2:0]         read_page;
        logic [6:0]         read_column;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       glyph_done;
    } res_item_t;

endpackage

/* hw/rtl/glyph_blit_page_framebuffer.sv */
// glyph_blit_page_framebuffer: page-organized monochrome framebuffer with
// a bit-serial glyph writer, fill sweep and byte read; uses gbpf_pkg
// a bitmap byte is handled one bit per cycle through a read-modify-write
// pipe on the store (one read and one write port), plus a drain; a fill
// sweep writes one store byte per cycle
// an item may be started in the cycle its predecessor's result is shown
// reset: busy while the store is cleared
// result shows for one cycle with result_valid; the receiver cannot stall
module glyph_blit_page_framebuffer #(
    parameter int DISPLAY_WIDTH  = gbpf_pkg::DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = gbpf_pkg::DISPLAY_HEIGHT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  gbpf_pkg::in_item_t  item,
    output logic                result_valid,
    output gbpf_pkg::res_item_t result
);
    import gbpf_pkg::*;

    localparam int PAGE_COUNT = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_SIZE = PAGE_COUNT * DISPLAY_WIDTH;
    localparam int AW         = $clog2(STORE_SIZE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_SIZE - 1);
    localparam logic [10:0]   W11       = 11'(DISPLAY_WIDTH);
    localparam logic [10:0]   H11       = 11'(DISPLAY_HEIGHT);

    logic [7:0] fb_mem [STORE_SIZE];

    state_t        state_reg, state_next;
    logic [AW-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic [7:0]    fill_val_reg, fill_val_next;
    logic [10:0]   base_x_reg, base_x_next;
    logic [10:0]   base_y_reg, base_y_next;
    logic [7:0]    gl_width_reg, gl_width_next;
    logic [7:0]    gl_height_reg, gl_height_next;
    logic [7:0]    cur_col_reg, cur_col_next;
    logic [7:0]    cur_row_reg, cur_row_next;
    logic [7:0]    bits_reg, bits_next;
    logic [2:0]    bit_cnt_reg, bit_cnt_next;
    logic          wr_pend_reg, wr_pend_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic [7:0]    wr_mask_reg, wr_mask_next;
    logic          last_we_reg;
    logic [AW-1:0] last_addr_reg;
    logic [7:0]    last_data_reg;
    logic          read_ok_reg, read_ok_next;
    logic [7:0]    read_data_reg, read_data_next;
    logic          result_valid_reg, result_valid_next;
    logic [7:0]    mem_rd_reg;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    logic          finished;
    logic [10:0]   px, py;
    logic          pix_in;
    logic [AW-1:0] pix_addr, rd_item_addr;
    logic          rd_item_ok;
    logic [7:0]    merge_base, col_inc;

    assign finished = (gl_width_reg == 8'd0) || (gl_height_reg == 8'd0) ||
                      (cur_row_reg >= gl_height_reg);

    assign px     = base_x_reg + {3'b000, cur_col_reg};
    assign py     = base_y_reg + {3'b000, cur_row_reg};
    assign pix_in = !px[10] && (px < W11) && !py[10] && (py < H11);
    assign pix_addr = AW'(32'(py[5:3]) * DISPLAY_WIDTH + 32'(px[7:0]));
    assign col_inc  = cur_col_reg + 8'd1;

    assign rd_item_ok   = (32'(item.read_page) < PAGE_COUNT) &&
                          (32'(item.read_column) < DISPLAY_WIDTH);
    assign rd_item_addr = AW'(32'(item.read_page) * DISPLAY_WIDTH +
                              32'(item.read_column));

    // forward the previous cycle's write when the pipe hits the same byte
    assign merge_base = (last_we_reg && last_addr_reg == wr_addr_reg) ?
                        last_data_reg : mem_rd_reg;

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result.read_data  = read_data_reg;
    assign result.glyph_done = finished;

    // store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fb_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rd_reg <= fb_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            sweep_cnt_reg    <= '0;
            base_x_reg       <= '0;
            base_y_reg       <= '0;
            gl_width_reg     <= '0;
            gl_height_reg    <= '0;
            cur_col_reg      <= '0;
            cur_row_reg      <= '0;
            bit_cnt_reg      <= '0;
            wr_pend_reg      <= 1'b0;
            last_we_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_cnt_reg    <= sweep_cnt_next;
            base_x_reg       <= base_x_next;
            base_y_reg       <= base_y_next;
            gl_width_reg     <= gl_width_next;
            gl_height_reg    <= gl_height_next;
            cur_col_reg      <= cur_col_next;
            cur_row_reg      <= cur_row_next;
            bit_cnt_reg      <= bit_cnt_next;
            wr_pend_reg      <= wr_pend_next;
            last_we_reg      <= mem_we;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_val_reg  <= fill_val_next;
        bits_reg      <= bits_next;
        wr_addr_reg   <= wr_addr_next;
        wr_mask_reg   <= wr_mask_next;
        last_addr_reg <= mem_waddr;
        last_data_reg <= mem_wdata;
        read_ok_reg   <= read_ok_next;
        read_data_reg <= read_data_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        sweep_cnt_next    = sweep_cnt_reg;
        fill_val_next     = fill_val_reg;
        base_x_next       = base_x_reg;
        base_y_next       = base_y_reg;
        gl_width_next     = gl_width_reg;
        gl_height_next    = gl_height_reg;
        cur_col_next      = cur_col_reg;
        cur_row_next      = cur_row_reg;
        bits_next         = bits_reg;
        bit_cnt_next      = bit_cnt_reg;
        wr_pend_next      = 1'b0;
        wr_addr_next      = wr_addr_reg;
        wr_mask_next      = wr_mask_reg;
        read_ok_next      = read_ok_reg;
        read_data_next    = read_data_reg;
        result_valid_next = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = wr_addr_reg;
        mem_wdata         = merge_base | wr_mask_reg;
        mem_re            = 1'b0;
        mem_raddr         = pix_addr;

        // second half of the read-modify-write pipe
        if (wr_pend_reg)
        begin
            mem_we = 1'b1;
        end

        unique case (state_reg)
            ST_INIT, ST_FILL:
            begin
                mem_we         = 1'b1;
                mem_waddr      = sweep_cnt_reg;
                mem_wdata      = (state_reg == ST_INIT) ? 8'h00 : fill_val_reg;
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == LAST_ADDR)
                begin
                    state_next        = ST_IDLE;
                    result_valid_next = (state_reg == ST_FILL);
                    read_data_next    = 8'h00;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (item.kind)
                        KIND_HEADER:
                        begin
                            base_x_next = {3'b000, item.origin_x} +
                                          {{3{item.x_offset[7]}}, item.x_offset};
                            base_y_next = {3'b000, item.origin_y} +
                                          {{3{item.y_offset[7]}}, item.y_offset};
                            gl_width_next     = item.glyph_width;
                            gl_height_next    = item.glyph_height;
                            cur_col_next      = 8'd0;
                            cur_row_next      = 8'd0;
                            read_data_next    = 8'h00;
                            result_valid_next = 1'b1;
                        end
                        KIND_BITMAP:
                        begin
                            bits_next    = item.bitmap_byte;
                            bit_cnt_next = 3'd0;
                            state_next   = ST_BITS;
                        end
                        KIND_FILL:
                        begin
                            fill_val_next  = item.fill_ones ? 8'hff : 8'h00;
                            sweep_cnt_next = '0;
                            state_next     = ST_FILL;
                        end
                        KIND_READ:
                        begin
                            mem_re       = 1'b1;
                            mem_raddr    = rd_item_addr;
                            read_ok_next = rd_item_ok;
                            state_next   = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_BITS:
            begin
                if (finished)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    // first half: fetch the byte under a set, visible pixel
                    if (bits_reg[7] && pix_in)
                    begin
                        mem_re       = 1'b1;
                        wr_pend_next = 1'b1;
                        wr_addr_next = pix_addr;
                        wr_mask_next = 8'h01 << py[2:0];
                    end
                    if (col_inc >= gl_width_reg)
                    begin
                        cur_col_next = 8'd0;
                        cur_row_next = cur_row_reg + 8'd1;
                    end
                    else
                    begin
                        cur_col_next = col_inc;
                    end
                    bits_next    = {bits_reg[6:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                    if (bit_cnt_reg == 3'd7)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next        = ST_IDLE;
                read_data_next    = 8'h00;
                result_valid_next = 1'b1;
            end
            ST_READ:
            begin
                state_next        = ST_IDLE;
                read_data_next    = read_ok_reg ? mem_rd_reg : 8'h00;
                result_valid_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
